>>> design/ffba_pkg.sv
// Shared types and constants of the first-fit bump region allocator.
// Depends on nothing; the top level and ffba_ctrl import it.
`default_nettype none

package ffba_pkg;

  // Width of offsets and lengths within the zone.
  localparam int OFS_W = 25;
  // Width of absolute addresses and request sizes.
  localparam int ADDR_W = 32;
  // Width of the result status code.
  localparam int STATUS_W = 3;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Default depth of the region table.
  localparam int MAX_REGIONS_DEF = 1024;
  // New regions start on this byte boundary.
  localparam int ALIGN_BYTES = 8;
  // Reset value of the zone size register.
  localparam logic [OFS_W-1:0] ZONE_SIZE_RESET = OFS_W'(12 * 1024);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZONE_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SIZE  = 2'd2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Zone configuration as seen by the controller.
  typedef struct packed {
    logic              ready;
    logic [ADDR_W-1:0] base;
    logic [OFS_W-1:0]  size;
  } zone_cfg_t;

  // One entry of the region table.
  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [OFS_W-1:0] length;
    logic             in_use;
  } region_t;

  localparam int REGION_W = $bits(region_t);

endpackage

`default_nettype wire

>>> design/first_fit_bump_region_allocator.sv
// Top level of the first-fit bump region allocator: configuration registers,
// the region table RAM (ffba_ram) and the request sequencer (ffba_ctrl).
// Depends on ffba_pkg.
//
//   Channel  | Handshake               | Word
//   ---------+-------------------------+-------------------------------------
//   request  | start high, busy low    | in_kind, in_request_size,
//            |                         | in_free_address
//   result   | out_valid, one cycle    | out_status, out_address, out_reused
//   config   | cfg_valid and cfg_ready | cfg_index, cfg_data
//
// A request scans the table one entry per cycle through the RAM read port,
// and is decided at once when nothing is recorded or the zone is not ready;
// otherwise the scan stops at the matching entry, or after the last recorded
// entry on a miss. The result word shows in the cycle after the decision,
// when busy is low again.
// Reset is synchronous and clears the counts; the table needs no clearing.
// The receiver cannot stall results; configuration writes are always taken.
`default_nettype none

module first_fit_bump_region_allocator #(
  parameter int MAX_REGIONS = ffba_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_kind,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      in_request_size,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      in_free_address,
  output logic                                  out_valid,
  output logic      [ffba_pkg::STATUS_W-1:0]    out_status,
  output logic      [ffba_pkg::ADDR_W-1:0]      out_address,
  output logic                                  out_reused,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      cfg_data
);

  import ffba_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  zone_cfg_t   zone_cfg_r;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;
  region_t     ram_wdata;
  logic        ram_re;
  logic [IDX_W-1:0] ram_raddr;
  region_t     ram_rdata;

  // Configuration registers; a write is taken in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_cfg_r.ready <= 1'b0;
      zone_cfg_r.base  <= '0;
      zone_cfg_r.size  <= ZONE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZONE_READY: zone_cfg_r.ready <= cfg_data[0];
        CFG_ZONE_BASE:  zone_cfg_r.base  <= cfg_data;
        CFG_ZONE_SIZE:  zone_cfg_r.size  <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Region table.
  ffba_ram #(
    .WIDTH (REGION_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer.
  ffba_ctrl #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .zone_cfg        (zone_cfg_r),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_reused      (out_reused),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

endmodule

`default_nettype wire

>>> design/ffba_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data appears in the cycle after the address, when re is high.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/ffba_ctrl.sv
// Request sequencer: scans the region table memory, decides and writes back.
// Depends on ffba_pkg; drives the read and write ports of the region RAM.
`default_nettype none

module ffba_ctrl #(
  parameter int MAX_REGIONS = ffba_pkg::MAX_REGIONS_DEF,
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  localparam int CNT_W = $clog2(MAX_REGIONS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ffba_pkg::zone_cfg_t             zone_cfg,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_kind,
  input  wire logic [ffba_pkg::ADDR_W-1:0]     in_request_size,
  input  wire logic [ffba_pkg::ADDR_W-1:0]     in_free_address,
  output logic                                 out_valid,
  output logic      [ffba_pkg::STATUS_W-1:0]   out_status,
  output logic      [ffba_pkg::ADDR_W-1:0]     out_address,
  output logic                                 out_reused,
  output logic                                 ram_we,
  output logic      [IDX_W-1:0]                ram_waddr,
  output ffba_pkg::region_t                    ram_wdata,
  output logic                                 ram_re,
  output logic      [IDX_W-1:0]                ram_raddr,
  input  wire ffba_pkg::region_t               ram_rdata
);

  import ffba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  localparam int ALN_W = OFS_W + 1;
  localparam logic [ALN_W-1:0] ALIGN_M1 = ALN_W'(ALIGN_BYTES - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OFS_W-1:0]  bump_r, bump_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              kind_r;
  logic [ADDR_W-1:0] size_r;
  logic [ADDR_W-1:0] faddr_r;
  logic              ov_r, ov_nxt;
  logic [STATUS_W-1:0] os_r, os_nxt;
  logic [ADDR_W-1:0] oa_r, oa_nxt;
  logic              or_r, or_nxt;

  logic              accept;
  logic [ALN_W-1:0]  aligned;
  logic [ADDR_W:0]   bump_end;
  logic              bump_fits;
  logic              hit;
  logic              last_chk;
  logic [ADDR_W-1:0] entry_addr;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Rounded bump offset and whether a new region would fit in the zone.
  assign aligned   = (ALN_W'(bump_r) + ALIGN_M1) & ~ALIGN_M1;
  assign bump_end  = (ADDR_W + 1)'(aligned) + (ADDR_W + 1)'(size_r);
  assign bump_fits = (bump_end <= (ADDR_W + 1)'(zone_cfg.size));

  // Compare of the entry read in the previous cycle.
  assign entry_addr = zone_cfg.base + ADDR_W'(ram_rdata.offset);
  always_comb begin
    if (kind_r == KIND_ALLOC) begin
      hit = !ram_rdata.in_use && (ADDR_W'(ram_rdata.length) >= size_r);
    end else begin
      hit = (entry_addr == faddr_r);
    end
  end
  assign last_chk = (CNT_W'(chk_idx_r) + CNT_W'(1)) == count_r;

  // Table read: one entry per cycle in order, only below the fill count.
  assign ram_re    = (state_r == S_SCAN) && (issue_r < count_r);
  assign ram_raddr = issue_r[IDX_W-1:0];

  // Sequencer and decision logic.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    bump_nxt    = bump_r;
    issue_nxt   = issue_r;
    chk_idx_nxt = chk_idx_r;
    chk_vld_nxt = 1'b0;
    ov_nxt      = 1'b0;
    os_nxt      = os_r;
    oa_nxt      = oa_r;
    or_nxt      = or_r;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_r;
    ram_wdata   = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          issue_nxt = '0;
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          issue_nxt   = issue_r + CNT_W'(1);
          chk_idx_nxt = issue_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
        end
        if (!zone_cfg.ready) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          os_nxt    = ST_NOT_READY;
          oa_nxt    = '0;
          or_nxt    = 1'b0;
        end else if (chk_vld_r && hit) begin
          // Reuse or release the matching entry.
          state_nxt        = S_IDLE;
          ov_nxt           = 1'b1;
          os_nxt           = ST_OK;
          ram_we           = 1'b1;
          ram_waddr        = chk_idx_r;
          ram_wdata        = ram_rdata;
          ram_wdata.in_use = (kind_r == KIND_ALLOC);
          oa_nxt           = (kind_r == KIND_ALLOC) ? entry_addr : '0;
          or_nxt           = (kind_r == KIND_ALLOC);
        end else if ((count_r == '0) || (chk_vld_r && last_chk)) begin
          // No recorded region matched.
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          oa_nxt    = '0;
          or_nxt    = 1'b0;
          if (kind_r == KIND_FREE) begin
            os_nxt = ST_NOT_FOUND;
          end else if (count_r == CNT_W'(MAX_REGIONS)) begin
            os_nxt = ST_TABLE_FULL;
          end else if (!bump_fits) begin
            os_nxt = ST_ZONE_FULL;
          end else begin
            os_nxt           = ST_OK;
            oa_nxt           = zone_cfg.base + ADDR_W'(aligned);
            ram_we           = 1'b1;
            ram_waddr        = count_r[IDX_W-1:0];
            ram_wdata.offset = aligned[OFS_W-1:0];
            ram_wdata.length = size_r[OFS_W-1:0];
            ram_wdata.in_use = 1'b1;
            bump_nxt         = bump_end[OFS_W-1:0];
            count_nxt        = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      bump_r    <= '0;
      issue_r   <= '0;
      chk_idx_r <= '0;
      chk_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      bump_r    <= bump_nxt;
      issue_r   <= issue_nxt;
      chk_idx_r <= chk_idx_nxt;
      chk_vld_r <= chk_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Request word and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      size_r  <= in_request_size;
      faddr_r <= in_free_address;
    end
    os_r <= os_nxt;
    oa_r <= oa_nxt;
    or_r <= or_nxt;
  end

  assign out_valid   = ov_r;
  assign out_status  = os_r;
  assign out_address = oa_r;
  assign out_reused  = or_r;

`ifndef NO_ASSERTIONS
  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count above table depth");

  // Table writes happen only while a request is being decided.
  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN) && ov_nxt)
    else $error("table write outside a decision");

  // A result word follows a scan cycle and leaves the block idle.
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && ov_r |-> ($past(state_r) == S_SCAN) && (state_r == S_IDLE))
    else $error("result without a finished scan");

  // The bump offset moves only when a new region is recorded.
  a_bump_with_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(bump_r) |-> count_r == $past(count_r) + CNT_W'(1))
    else $error("bump offset moved without a new region");
`endif

endmodule

`default_nettype wire

>>> sim/first_fit_bump_region_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit bump region allocator: a scripted
// directed part, random phases under several zone settings and a table fill.
// Depends on ffba_pkg and first_fit_bump_region_allocator.

module first_fit_bump_region_allocator_test;
  import ffba_pkg::*;

  localparam int MAX_REGIONS = MAX_REGIONS_DEF;
  // Largest aligned zone size, so the bump offset can always be rounded up.
  localparam logic [OFS_W-1:0] ZONE_TOP = OFS_W'(33554424);
  localparam logic [OFS_W-1:0] ZONE_WORK_HIGH = OFS_W'(16777216);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 8000000;

  typedef logic [ADDR_W+1:0] wide_t;

  // One result word of the allocator.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic                reused;
  } alloc_reply_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_FIXED} row_op_t;

  // One row of the directed script. For a register write, addr holds the data.
  typedef struct packed {
    row_op_t              op;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 kind;
    logic [ADDR_W-1:0]    size;
    logic [ADDR_W-1:0]    addr;
    alloc_reply_t         reply;
  } script_row_t;

  localparam int SCRIPT_LEN = 34;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_kind = KIND_ALLOC;
  logic [ADDR_W-1:0]    in_request_size = '0;
  logic [ADDR_W-1:0]    in_free_address = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ADDR_W-1:0]    out_address;
  logic                 out_reused;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  // Predicted allocator state: zone registers, region table and bump offset.
  zone_cfg_t        zone = '{ready: 1'b0, base: '0, size: ZONE_SIZE_RESET};
  logic [OFS_W-1:0] region_ofs [MAX_REGIONS];
  logic [OFS_W-1:0] region_len [MAX_REGIONS];
  bit               region_taken [MAX_REGIONS];
  int unsigned      region_count = 0;
  logic [OFS_W-1:0] bump_ofs = '0;

  alloc_reply_t awaited_replies [$];
  int unsigned  awaited_seq [$];

  int unsigned sender_idle_pct = 0;
  int unsigned items_issued = 0;
  int unsigned replies_checked = 0;
  int unsigned reuse_count = 0;
  int unsigned status_seen [8];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd16, '1, '{ST_NOT_READY, 32'd0, 1'b0}},
    '{ROW_FIXED, '0, KIND_FREE, '1, 32'd0, '{ST_NOT_READY, 32'd0, 1'b0}},
    '{ROW_WRITE, CFG_ZONE_BASE, KIND_ALLOC, '0, 32'hFFFF_FFF8, '0},
    '{ROW_WRITE, CFG_SPARE, KIND_ALLOC, '0, '1, '0},
    '{ROW_WRITE, CFG_ZONE_READY, KIND_ALLOC, '0, 32'd1, '0},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd0, 32'hA5A5_5A5A, '{ST_OK, 32'hFFFF_FFF8, 1'b0}},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd5, '1, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd3, '0, '0},
    '{ROW_PREDICT, '0, KIND_FREE, '1, 32'hFFFF_FFF8, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd0, '1, '0},
    '{ROW_FIXED, '0, KIND_FREE, '0, 32'h0001_2345, '{ST_NOT_FOUND, 32'd0, 1'b0}},
    '{ROW_PREDICT, '0, KIND_FREE, '1, 32'hFFFF_FFF8, '0},
    '{ROW_PREDICT, '0, KIND_FREE, '0, 32'hFFFF_FFF8, '0},
    '{ROW_FIXED, '0, KIND_ALLOC, '1, '1, '{ST_ZONE_FULL, 32'd0, 1'b0}},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd12288, '0, '{ST_ZONE_FULL, 32'd0, 1'b0}},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd12272, '1, '0},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd1, '0, '{ST_ZONE_FULL, 32'd0, 1'b0}},
    '{ROW_FIXED, '0, KIND_FREE, '1, '1, '{ST_NOT_FOUND, 32'd0, 1'b0}},
    '{ROW_WRITE, CFG_ZONE_SIZE, KIND_ALLOC, '0, 32'd0, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd0, '0, '0},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd0, '1, '{ST_ZONE_FULL, 32'd0, 1'b0}},
    '{ROW_WRITE, CFG_ZONE_BASE, KIND_ALLOC, '0, 32'd3, '0},
    '{ROW_WRITE, CFG_ZONE_SIZE, KIND_ALLOC, '0, 32'h01FF_FFFF, '0},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'h01FF_FFFF, '0, '{ST_ZONE_FULL, 32'd0, 1'b0}},
    '{ROW_PREDICT, '0, KIND_FREE, '0, 32'h0000_000B, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd2, '1, '0},
    '{ROW_WRITE, CFG_ZONE_SIZE, KIND_ALLOC, '0, 32'd16777216, '0},
    '{ROW_WRITE, CFG_ZONE_READY, KIND_ALLOC, '0, 32'd0, '0},
    '{ROW_FIXED, '0, KIND_FREE, '1, 32'd3, '{ST_NOT_READY, 32'd0, 1'b0}},
    '{ROW_FIXED, '0, KIND_ALLOC, 32'd0, '0, '{ST_NOT_READY, 32'd0, 1'b0}},
    '{ROW_WRITE, CFG_ZONE_READY, KIND_ALLOC, '0, 32'd1, '0},
    '{ROW_WRITE, CFG_ZONE_BASE, KIND_ALLOC, '0, 32'd0, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd7, '0, '0},
    '{ROW_PREDICT, '0, KIND_ALLOC, 32'd1, '1, '0}
  };

  first_fit_bump_region_allocator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_reused      (out_reused),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the allocator's answer to one request and updates the table.
  function automatic alloc_reply_t zone_reply(input logic kind,
      input logic [ADDR_W-1:0] size, input logic [ADDR_W-1:0] addr);
    alloc_reply_t reply;
    wide_t        rounded;
    bit           hit;
    reply = '{status: ST_OK, address: '0, reused: 1'b0};
    hit = 1'b0;
    if (!zone.ready) begin
      reply.status = ST_NOT_READY;
    end else if (kind == KIND_ALLOC) begin
      // First fit: reuse the earliest free region that is large enough.
      for (int unsigned i = 0; i < region_count && !hit; i++) begin
        if (!region_taken[i] && ADDR_W'(region_len[i]) >= size) begin
          region_taken[i] = 1'b1;
          reply.address = zone.base + ADDR_W'(region_ofs[i]);
          reply.reused = 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        // Otherwise carve a new region at the aligned bump offset.
        rounded = (wide_t'(bump_ofs) + wide_t'(ALIGN_BYTES - 1)) & ~wide_t'(ALIGN_BYTES - 1);
        if (region_count >= MAX_REGIONS) begin
          reply.status = ST_TABLE_FULL;
        end else if (rounded + wide_t'(size) > wide_t'(zone.size)) begin
          reply.status = ST_ZONE_FULL;
        end else begin
          region_ofs[region_count] = OFS_W'(rounded);
          region_len[region_count] = OFS_W'(size);
          region_taken[region_count] = 1'b1;
          bump_ofs = OFS_W'(rounded + wide_t'(size));
          region_count++;
          reply.address = zone.base + ADDR_W'(rounded);
        end
      end
    end else begin
      // A free releases only the first region whose base matches.
      for (int unsigned i = 0; i < region_count && !hit; i++) begin
        if (zone.base + ADDR_W'(region_ofs[i]) == addr) begin
          region_taken[i] = 1'b0;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        reply.status = ST_NOT_FOUND;
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned seq,
      input logic [ADDR_W-1:0] got, input logic [ADDR_W-1:0] want);
    $display("%0t: mismatch on request %0d, %s: got %0h, want %0h", $time, seq, what, got,
             want);
    mismatches++;
  endtask

  // Lowers start and waits until every owed word has come and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0 || busy) @(posedge clk);
  endtask

  // Writes one zone register once the block is idle.
  task automatic write_zone_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ZONE_READY: zone.ready = data[0];
      CFG_ZONE_BASE: zone.base = data;
      CFG_ZONE_SIZE: zone.size = data[OFS_W-1:0];
      default: ;
    endcase
  endtask

  // Sends one request word; start is left high for a following word.
  task automatic issue_request(input logic kind, input logic [ADDR_W-1:0] size,
      input logic [ADDR_W-1:0] addr, input bit fixed, input alloc_reply_t fixed_reply);
    alloc_reply_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_request_size <= size;
    in_free_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = zone_reply(kind, size, addr);
    awaited_replies.push_back(fixed ? fixed_reply : predicted);
    awaited_seq.push_back(items_issued);
    items_issued++;
  endtask

  // Mostly well-formed traffic: small allocations and frees of recorded region bases.
  task automatic random_item();
    logic              kind;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    int unsigned       pick;
    kind = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_FREE;
    size = $urandom;
    addr = $urandom;
    pick = $urandom_range(0, 99);
    if (kind == KIND_ALLOC) begin
      if (pick < 70) begin
        size = $urandom_range(0, 64);
      end else if (pick < 85) begin
        size = $urandom_range(0, 4096);
      end else if (pick >= 95) begin
        size = $urandom_range(0, 1) ? '0 : '1;
      end
    end else if (region_count > 0 && pick < 80) begin
      addr = zone.base + ADDR_W'(region_ofs[$urandom_range(0, region_count - 1)]);
    end
    issue_request(kind, size, addr, 1'b0, '0);
  endtask

  // One random phase under a given zone setting and sender idle rate.
  task automatic run_phase(input logic ready, input logic [ADDR_W-1:0] base,
      input logic [OFS_W-1:0] size, input int unsigned idle_pct, input int unsigned count);
    write_zone_reg(CFG_ZONE_READY, ADDR_W'(ready));
    write_zone_reg(CFG_ZONE_BASE, base);
    write_zone_reg(CFG_ZONE_SIZE, ADDR_W'(size));
    sender_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      random_item();
    end
  endtask

  // Result checker: each strobed word is matched against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("result with nothing owed", items_issued, out_address, '0);
      end else begin
        if (out_status != awaited_replies[0].status)
          report_mismatch("status", awaited_seq[0], ADDR_W'(out_status),
                          ADDR_W'(awaited_replies[0].status));
        if (out_address != awaited_replies[0].address)
          report_mismatch("address", awaited_seq[0], out_address, awaited_replies[0].address);
        if (out_reused != awaited_replies[0].reused)
          report_mismatch("reused", awaited_seq[0], ADDR_W'(out_reused),
                          ADDR_W'(awaited_replies[0].reused));
        status_seen[out_status]++;
        if (out_reused) reuse_count++;
        replies_checked++;
        void'(awaited_replies.pop_front());
        void'(awaited_seq.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words owed", cycle_count,
               awaited_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script.
    sender_idle_pct = 0;
    foreach (script[r]) begin
      if (script[r].op == ROW_WRITE) begin
        write_zone_reg(script[r].reg_idx, script[r].addr);
      end else begin
        issue_request(script[r].kind, script[r].size, script[r].addr,
                      script[r].op == ROW_FIXED, script[r].reply);
      end
    end

    // Random phases over several zone settings and idle rates.
    run_phase(1'b1, $urandom & ~32'd7, OFS_W'(12288), 0, 95);
    run_phase(1'b1, $urandom, OFS_W'($urandom_range(0, 2048)), 46, 95);
    run_phase(1'b0, $urandom, ZONE_TOP, 10, 15);
    run_phase(1'b1, 32'd0, ZONE_TOP, 10, 95);
    run_phase(1'b1, 32'hFFFF_FFF8, ZONE_WORK_HIGH, 46, 95);
    run_phase(1'b1, $urandom, OFS_W'($urandom_range(0, ZONE_TOP)), 0, 95);
    run_phase(1'b1, $urandom & ~32'd7, OFS_W'(12288), 10, 95);

    // Fill the table with zero-size regions, then hit the table-full case.
    write_zone_reg(CFG_ZONE_SIZE, ADDR_W'(ZONE_TOP));
    sender_idle_pct = 10;
    while (region_count < MAX_REGIONS) issue_request(KIND_ALLOC, '0, $urandom, 1'b0, '0);
    issue_request(KIND_ALLOC, '0, '0, 1'b1, '{ST_TABLE_FULL, 32'd0, 1'b0});
    issue_request(KIND_ALLOC, '1, '1, 1'b1, '{ST_TABLE_FULL, 32'd0, 1'b0});
    run_phase(1'b1, 32'hFFFF_FFF8, ZONE_TOP, 46, 30);

    // Let the last words come and any late stray word show.
    wait_drained();
    repeat (MAX_REGIONS + 8) @(posedge clk);

    $display("Ran %0d requests, %0d words checked, %0d regions recorded, %0d reuses",
             items_issued, replies_checked, region_count, reuse_count);
    $display("Status mix: ok %0d, table full %0d, zone full %0d, not ready %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_TABLE_FULL], status_seen[ST_ZONE_FULL],
             status_seen[ST_NOT_READY], status_seen[ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_ctrl.sv
design/first_fit_bump_region_allocator.sv
sim/first_fit_bump_region_allocator_test.sv
